// ----- design/bitmap_slot_allocator_core_macros.svh -----
// Assertion macros used by the allocator RTL.
`ifndef BITMAP_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/bsa_pkg.sv -----
// Shared types and constants of the bitmap slot allocator.
package bsa_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int NUM_WORDS_DEF = 32;
	localparam int SLOT_W        = 10;
	localparam int STATUS_W      = 2;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_RANGE     = 2'd2,
		ST_NOT_ALLOC = 2'd3
	} status_t;

endpackage

// ----- design/bsa_ifs.sv -----
// Request and response channel interfaces of the bitmap slot allocator.
interface bsa_req_if;
	import bsa_pkg::*;

	logic                valid;
	logic                ready;
	op_t                 opcode;
	logic [SLOT_W-1:0]   slot_in;

	modport source (output valid, output opcode, output slot_in, input ready);
	modport sink   (input valid, input opcode, input slot_in, output ready);
endinterface

interface bsa_rsp_if;
	import bsa_pkg::*;

	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   slot_out;
	status_t             status;

	modport source (output valid, output slot_out, output status, input ready);
	modport sink   (input valid, input slot_out, input status, output ready);
endinterface

// ----- design/bsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- design/bitmap_slot_allocator_core.sv -----
// Bitmap slot allocator: first-fit allocate and checked free over a slot bitmap held in a RAM.
// After reset the block clears the bitmap RAM, one word a cycle, and accepts no request until
// that pass ends. A free goes through accept, one RAM read and result; a free out of range
// skips the read. An allocate starts its scan at a hint, the lowest word that may have a clear
// bit, and reads on past every full word, one RAM read each; the single RAM read port sets
// that pace. Once the scan finds every word full the hint marks the store full and later
// allocates answer without a RAM read until a free lands. A result waits in the output
// register while the consumer stalls, and the next request is not taken until it has been
// handed to that register.
module bitmap_slot_allocator_core #(
	parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF,
	parameter int NUM_WORDS = bsa_pkg::NUM_WORDS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	bsa_req_if.sink  req,
	bsa_rsp_if.source rsp
);
	import bsa_pkg::*;

	`include "bitmap_slot_allocator_core_macros.svh"

	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int HW        = $clog2(NUM_WORDS + 1);
	localparam int BW        = $clog2(WORD_BITS);
	localparam int CAP       = WORD_BITS * NUM_WORDS;
	localparam int DIV_SHIFT = SLOT_W + 7;
	localparam int DIV_MUL   = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
	localparam int MUL_W     = DIV_SHIFT + 1;
	localparam int PROD_W    = SLOT_W + MUL_W;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_CHECK = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t               st_q;
	logic [AW-1:0]        clr_cnt_q;
	logic [HW-1:0]        hint_q;
	op_t                  op_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [AW-1:0]        addr_q;
	logic [SLOT_W-1:0]    res_slot_q;
	status_t              res_status_q;
	logic                 out_valid_q;
	logic [SLOT_W-1:0]    out_slot_q;
	status_t              out_status_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] rdata;

	logic                 accept;
	logic                 store_full;
	logic                 in_range;
	logic [PROD_W-1:0]    div_prod;
	logic [AW-1:0]        req_word;
	logic [31:0]          word_base;
	logic [31:0]          free_off;
	logic [BW-1:0]        free_bit;
	logic [BW-1:0]        ffz_idx;
	logic [31:0]          alloc_slot;
	logic                 word_full;
	logic                 last_word;
	logic                 load_out;
	logic [WORD_BITS-1:0] one_bit;

	bsa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	assign req.ready  = (st_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign store_full = (hint_q == HW'(NUM_WORDS));
	assign in_range   = ({{(32-SLOT_W){1'b0}}, req.slot_in} < 32'(CAP));

	// Word index of a slot: multiply by a reciprocal, exact for every 10-bit slot.
	assign div_prod  = PROD_W'(req.slot_in) * PROD_W'(DIV_MUL);
	assign req_word  = div_prod[DIV_SHIFT +: AW];

	assign word_base  = 32'(addr_q) * 32'(WORD_BITS);
	assign free_off   = {{(32-SLOT_W){1'b0}}, slot_q} - word_base;
	assign free_bit   = free_off[BW-1:0];
	assign alloc_slot = word_base + 32'(ffz_idx);
	assign word_full  = &rdata;
	assign last_word  = (addr_q == AW'(NUM_WORDS - 1));
	assign one_bit    = {{(WORD_BITS-1){1'b0}}, 1'b1};
	assign load_out   = (st_q == S_DONE) && (!out_valid_q || rsp.ready);

	// Lowest clear bit of the word just read.
	always_comb begin
		ffz_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!rdata[i]) begin
				ffz_idx = BW'(i);
			end
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = rdata;
		case (st_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				if (accept) begin
					if (req.opcode == OP_ALLOC) begin
						ram_re    = !store_full;
						ram_raddr = hint_q[AW-1:0];
					end else begin
						ram_re    = in_range;
						ram_raddr = req_word;
					end
				end
			end
			S_CHECK: begin
				if (op_q == OP_ALLOC) begin
					if (word_full) begin
						ram_re    = !last_word;
						ram_raddr = addr_q + AW'(1);
					end else begin
						ram_we    = 1'b1;
						ram_wdata = rdata | (one_bit << ffz_idx);
					end
				end else if (rdata[free_bit]) begin
					ram_we    = 1'b1;
					ram_wdata = rdata & ~(one_bit << free_bit);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_CLEAR;
			clr_cnt_q <= '0;
			hint_q    <= '0;
		end else begin
			case (st_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(NUM_WORDS - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (req.opcode == OP_ALLOC) begin
							st_q <= store_full ? S_DONE : S_CHECK;
						end else begin
							st_q <= in_range ? S_CHECK : S_DONE;
						end
					end
				end
				S_CHECK: begin
					if (op_q == OP_ALLOC) begin
						if (word_full) begin
							// Advance the hint past a full word.
							hint_q <= last_word ? HW'(NUM_WORDS) : HW'(addr_q) + HW'(1);
							if (last_word) begin
								st_q <= S_DONE;
							end
						end else begin
							st_q <= S_DONE;
						end
					end else begin
						if (rdata[free_bit] && (HW'(addr_q) < hint_q)) begin
							hint_q <= HW'(addr_q);
						end
						st_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					op_q   <= req.opcode;
					slot_q <= req.slot_in;
					if (req.opcode == OP_ALLOC) begin
						addr_q       <= hint_q[AW-1:0];
						res_slot_q   <= '0;
						res_status_q <= ST_FULL;
					end else begin
						addr_q       <= req_word;
						res_slot_q   <= req.slot_in;
						res_status_q <= ST_RANGE;
					end
				end
			end
			S_CHECK: begin
				if (op_q == OP_ALLOC) begin
					if (word_full) begin
						addr_q       <= addr_q + AW'(1);
						res_slot_q   <= '0;
						res_status_q <= ST_FULL;
					end else begin
						res_slot_q   <= alloc_slot[SLOT_W-1:0];
						res_status_q <= ST_OK;
					end
				end else begin
					res_slot_q   <= slot_q;
					res_status_q <= rdata[free_bit] ? ST_OK : ST_NOT_ALLOC;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_slot_q   <= res_slot_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.slot_out = out_slot_q;
	assign rsp.status   = out_status_q;

	`BSA_ASSERT_NOW(a_hint_bound, clk, arst_n, 1'b1, hint_q <= HW'(NUM_WORDS),
		"hint points beyond the bitmap")
	`BSA_ASSERT_NOW(a_no_accept_in_clear, clk, arst_n, st_q == S_CLEAR, !req.ready,
		"request taken during bitmap clear")
	`BSA_ASSERT_NOW(a_full_marks_hint, clk, arst_n,
		(st_q == S_DONE) && (op_q == OP_ALLOC) && (res_status_q == ST_FULL),
		store_full, "full status without the hint marking the store full")
	`BSA_ASSERT_NOW(a_write_states, clk, arst_n, ram_we,
		(st_q == S_CLEAR) || (st_q == S_CHECK), "bitmap written outside clear or check")
	`BSA_ASSERT_NEXT(a_check_leads_on, clk, arst_n,
		(st_q == S_CHECK) && !((op_q == OP_ALLOC) && word_full && !last_word),
		st_q == S_DONE, "check did not finish after its last read")
endmodule
